@@ design/psa_pkg.sv @@
// Package for the pooled slot allocator: request and response structs,
// request and status codes, field widths and the size code decoder.
// No dependencies.
package psa_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int POOLS_DEF = 4;

    // Field widths fixed by the interface
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;
    localparam int CODE_W = 8;
    localparam int PIDX_W = 3;

    // Slots examined per scan cycle
    localparam int SCAN_W = 8;

    localparam logic [CODE_W-1:0] SIZE_CODE_0 = 8'he8;
    localparam logic [CODE_W-1:0] SIZE_CODE_1 = 8'h94;
    localparam logic [CODE_W-1:0] SIZE_CODE_2 = 8'hac;
    localparam logic [CODE_W-1:0] SIZE_CODE_3 = 8'h18;

    typedef enum logic [1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_FREE     = 2'd1,
        REQ_USE      = 2'd2,
        REQ_FREE_ALL = 2'd3
    } psa_req_type_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } psa_status_t;

    typedef struct packed {
        psa_req_type_t       req_type;
        logic [CODE_W-1:0]   size_code;
        logic [SLOT_W-1:0]   slot;
    } psa_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        psa_status_t         status;
        logic [CNT_W-1:0]    pool_used;
    } psa_rsp_t;

    typedef struct packed {
        logic                hit;
        logic [PIDX_W-1:0]   idx;
    } psa_pool_sel_t;

    function automatic psa_pool_sel_t pool_of(input logic [CODE_W-1:0] code);
        psa_pool_sel_t sel;
        sel.hit = 1'b1;
        sel.idx = '0;
        case (code)
            SIZE_CODE_0: sel.idx = 3'd0;
            SIZE_CODE_1: sel.idx = 3'd1;
            SIZE_CODE_2: sel.idx = 3'd2;
            SIZE_CODE_3: sel.idx = 3'd3;
            default:     sel.hit = 1'b0;
        endcase
        return sel;
    endfunction

endpackage

@@ design/pooled_slot_allocator.sv @@
// Pooled slot allocator top level: per-pool busy bitmaps, created and in-use
// counts, and a sequencer around one eight-slot first-fit scanner.
// Depends on psa_pkg.

// Each request on the s_ channel produces exactly one response on the m_
// channel. The block takes one request at a time: s_ready is high only while
// the sequencer is idle, and a new request may be taken while the previous
// response still waits in the output register. Free, mark used, free all and
// requests with an unknown size code pass through the execute and result
// states to the output register. Allocate walks the pool's created slots eight
// at a time through one shared scan window, up to and including the first
// window that holds a free created slot, at most ceil(SLOTS/8) windows.
// Slot numbers are handed out lowest first; a pool with no free created slot
// creates the next one until SLOTS are created, after which allocate reports
// pool full. Reset clears all pools at once.
module pooled_slot_allocator #(
    parameter int SLOTS = psa_pkg::SLOTS_DEF,
    parameter int POOLS = psa_pkg::POOLS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  psa_pkg::psa_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output psa_pkg::psa_rsp_t m_data
);
    import psa_pkg::*;

    localparam int SLOT_IW = $clog2(SLOTS);
    localparam int POOL_W  = (POOLS > 1) ? $clog2(POOLS) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    psa_req_type_t       req_reg, req_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [POOL_W-1:0]   pool_reg, pool_next;
    logic                known_reg, known_next;
    logic [CNT_W-1:0]    base_reg, base_next;
    psa_rsp_t            res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    psa_rsp_t            m_data_reg, m_data_next;

    logic [SLOTS-1:0]    busy_reg [POOLS];
    logic [SLOTS-1:0]    busy_next [POOLS];
    logic [CNT_W-1:0]    created_reg [POOLS];
    logic [CNT_W-1:0]    created_next [POOLS];
    logic [CNT_W-1:0]    in_use_reg [POOLS];
    logic [CNT_W-1:0]    in_use_next [POOLS];

    psa_pool_sel_t       sel;
    logic                found;
    logic [2:0]          found_off;
    logic [CNT_W-1:0]    scan_idx;
    logic [CNT_W-1:0]    found_slot;
    logic [CNT_W:0]      base_step;
    logic [CNT_W-1:0]    cur_created;
    logic [CNT_W-1:0]    cur_in_use;
    logic                cur_bit;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign sel     = pool_of(s_data.size_code);

    assign cur_created = created_reg[pool_reg];
    assign cur_in_use  = in_use_reg[pool_reg];
    assign cur_bit     = busy_reg[pool_reg][slot_reg[SLOT_IW-1:0]];
    assign base_step   = {1'b0, base_reg} + (CNT_W+1)'(SCAN_W);

    // Scan window: lowest free created slot among the eight at base_reg
    always_comb begin
        found     = 1'b0;
        found_off = '0;
        scan_idx  = '0;
        for (int j = SCAN_W - 1; j >= 0; j--) begin
            scan_idx = base_reg + CNT_W'(j);
            if ((scan_idx < cur_created) && !busy_reg[pool_reg][scan_idx[SLOT_IW-1:0]]) begin
                found     = 1'b1;
                found_off = 3'(j);
            end
        end
        found_slot = base_reg + CNT_W'(found_off);
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        slot_next    = slot_reg;
        pool_next    = pool_reg;
        known_next   = known_reg;
        base_next    = base_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        busy_next    = busy_reg;
        created_next = created_reg;
        in_use_next  = in_use_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data.req_type;
                    slot_next  = s_data.slot;
                    pool_next  = sel.idx[POOL_W-1:0];
                    known_next = sel.hit && (32'(sel.idx) < POOLS);
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_next.granted_slot = '0;
                res_next.status       = ST_DONE;
                res_next.pool_used    = '0;
                state_next            = S_RESULT;
                if (req_reg == REQ_FREE_ALL) begin
                    for (int p = 0; p < POOLS; p++) begin
                        busy_next[p]   = '0;
                        in_use_next[p] = '0;
                    end
                end else if (!known_reg) begin
                    res_next.status = ST_UNKNOWN;
                end else if (req_reg == REQ_ALLOC) begin
                    base_next  = '0;
                    state_next = S_SCAN;
                end else begin
                    res_next.pool_used = cur_in_use;
                    // Ignore slots that were never created
                    if (CNT_W'(slot_reg) < cur_created) begin
                        if (req_reg == REQ_FREE && cur_bit) begin
                            busy_next[pool_reg][slot_reg[SLOT_IW-1:0]] = 1'b0;
                            in_use_next[pool_reg] = cur_in_use - CNT_W'(1);
                            res_next.pool_used    = cur_in_use - CNT_W'(1);
                        end else if (req_reg == REQ_USE && !cur_bit) begin
                            busy_next[pool_reg][slot_reg[SLOT_IW-1:0]] = 1'b1;
                            in_use_next[pool_reg] = cur_in_use + CNT_W'(1);
                            res_next.pool_used    = cur_in_use + CNT_W'(1);
                        end
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    busy_next[pool_reg][found_slot[SLOT_IW-1:0]] = 1'b1;
                    in_use_next[pool_reg] = cur_in_use + CNT_W'(1);
                    res_next.granted_slot = found_slot[SLOT_W-1:0];
                    res_next.pool_used    = cur_in_use + CNT_W'(1);
                    state_next            = S_RESULT;
                end else if (base_step >= {1'b0, cur_created}) begin
                    // No free created slot: create the next one, or report full
                    if (cur_created < CNT_W'(SLOTS)) begin
                        busy_next[pool_reg][cur_created[SLOT_IW-1:0]] = 1'b1;
                        created_next[pool_reg] = cur_created + CNT_W'(1);
                        in_use_next[pool_reg]  = cur_in_use + CNT_W'(1);
                        res_next.granted_slot  = cur_created[SLOT_W-1:0];
                        res_next.pool_used     = cur_in_use + CNT_W'(1);
                    end else begin
                        res_next.status    = ST_FULL;
                        res_next.pool_used = cur_in_use;
                    end
                    state_next = S_RESULT;
                end else begin
                    base_next = base_step[CNT_W-1:0];
                end
            end
            S_RESULT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            busy_reg    <= '{default: '0};
            created_reg <= '{default: '0};
            in_use_reg  <= '{default: '0};
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            busy_reg    <= busy_next;
            created_reg <= created_next;
            in_use_reg  <= in_use_next;
        end
        req_reg    <= req_next;
        slot_reg   <= slot_next;
        pool_reg   <= pool_next;
        known_reg  <= known_next;
        base_reg   <= base_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

@@ tb/psa_checker.sv @@
// Response checker for the pooled slot allocator: watches both channels,
// keeps its own copy of the pool bitmaps and counters, and compares every
// response with the one predicted for the oldest outstanding request.
// Depends on psa_pkg.
module psa_checker
    import psa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  psa_req_t s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  psa_rsp_t m_data,
    output int       fail_count,
    output int       rsp_outstanding
);

    localparam int NPOOL = POOLS_DEF;
    localparam int NSLOT = SLOTS_DEF;

    logic [NSLOT-1:0] busy_map   [NPOOL];
    logic [CNT_W-1:0] created_cnt[NPOOL];
    logic [CNT_W-1:0] in_use_cnt [NPOOL];

    psa_rsp_t rsp_due_q[$];
    int       mismatches = 0;
    int       due_count  = 0;

    assign fail_count      = mismatches;
    assign rsp_outstanding = due_count;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Apply one request to the shadow pools and return the response it earns.
    function automatic psa_rsp_t apply_request(input psa_req_t r);
        psa_rsp_t rsp;
        int       p;
        int       i;
        int       pick;
        bit       found;
        rsp.granted_slot = '0;
        rsp.status       = ST_DONE;
        rsp.pool_used    = '0;
        found            = 1'b0;
        pick             = 0;
        case (r.size_code)
            SIZE_CODE_0: p = 0;
            SIZE_CODE_1: p = 1;
            SIZE_CODE_2: p = 2;
            SIZE_CODE_3: p = 3;
            default:     p = -1;
        endcase
        if (p >= NPOOL) p = -1;

        if (r.req_type == REQ_FREE_ALL) begin
            for (i = 0; i < NPOOL; i++) begin
                busy_map[i]   = '0;
                in_use_cnt[i] = '0;
            end
        end else if (p < 0) begin
            rsp.status = ST_UNKNOWN;
        end else begin
            if (r.req_type == REQ_ALLOC) begin
                for (i = 0; i < NSLOT; i++) begin
                    if (!found && i < created_cnt[p] && !busy_map[p][i]) begin
                        found = 1'b1;
                        pick  = i;
                    end
                end
                if (!found) begin
                    if (created_cnt[p] < NSLOT) begin
                        pick           = created_cnt[p];
                        created_cnt[p] = created_cnt[p] + 1'b1;
                        found          = 1'b1;
                    end else begin
                        rsp.status = ST_FULL;
                    end
                end
                if (found) begin
                    busy_map[p][pick] = 1'b1;
                    in_use_cnt[p]     = in_use_cnt[p] + 1'b1;
                    rsp.granted_slot  = pick[SLOT_W-1:0];
                end
            end else if (r.slot < created_cnt[p]) begin
                if (r.req_type == REQ_FREE) begin
                    if (busy_map[p][r.slot]) begin
                        busy_map[p][r.slot] = 1'b0;
                        in_use_cnt[p]       = in_use_cnt[p] - 1'b1;
                    end
                end else if (!busy_map[p][r.slot]) begin
                    busy_map[p][r.slot] = 1'b1;
                    in_use_cnt[p]       = in_use_cnt[p] + 1'b1;
                end
            end
            rsp.pool_used = in_use_cnt[p];
        end
        return rsp;
    endfunction

    always @(posedge aclk) begin
        psa_rsp_t want;
        if (!aresetn) begin
            for (int k = 0; k < NPOOL; k++) begin
                busy_map[k]    = '0;
                created_cnt[k] = '0;
                in_use_cnt[k]  = '0;
            end
            rsp_due_q.delete();
        end else begin
            if (s_valid && s_ready) rsp_due_q.push_back(apply_request(s_data));
            if (m_valid && m_ready) begin
                if (rsp_due_q.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = rsp_due_q.pop_front();
                    if (m_data.granted_slot != want.granted_slot)
                        report_mismatch($sformatf("granted_slot got %0d want %0d",
                                                  m_data.granted_slot, want.granted_slot));
                    if (m_data.status != want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_data.status, want.status));
                    if (m_data.pool_used != want.pool_used)
                        report_mismatch($sformatf("pool_used got %0d want %0d",
                                                  m_data.pool_used, want.pool_used));
                end
            end
        end
        due_count = rsp_due_q.size();
    end

endmodule

@@ tb/pooled_slot_allocator_test.sv @@
// Top of the pooled slot allocator testbench: clock, reset, request stimulus
// and response back-pressure; the checker module does all prediction.
// Depends on psa_pkg, pooled_slot_allocator and psa_checker.
module pooled_slot_allocator_test;
    import psa_pkg::*;

    localparam int N_ITEMS     = 1650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 900;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    psa_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    psa_rsp_t m_data;

    int         fail_count;
    int         rsp_outstanding;
    int         sent = 0;
    int         cycles = 0;
    idle_mode_t idle_mode = IDLE_NONE;

    logic [CODE_W-1:0] pool_code[4];

    always #2 aclk = ~aclk;

    pooled_slot_allocator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    psa_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .rsp_outstanding (rsp_outstanding)
    );

    // Offer one request; valid stays high from the previous request unless a gap
    // is taken, so it is never dropped and raised in the same step.
    task automatic issue(input psa_req_type_t t, input logic [CODE_W-1:0] code,
                         input logic [SLOT_W-1:0] slot);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 61 : (idle_mode == IDLE_BOTH) ? 15 : 0;
        @(negedge aclk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_data.req_type  <= t;
        s_data.size_code <= code;
        s_data.slot      <= slot;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    function automatic logic [SLOT_W-1:0] pick_slot();
        return $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 63))
                                    : SLOT_W'($urandom_range(0, 15));
    endfunction

    // Response side: random stalls per idle mode, plus one long hold-off.
    initial begin
        int stall_pct;
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall_pct = (idle_mode == IDLE_RECV) ? 61 : (idle_mode == IDLE_BOTH) ? 15 : 0;
            if (!held && sent >= HOLD_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= !(aresetn && $urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int  pick;
        int  len;
        int  op;
        logic [CODE_W-1:0] code;

        pool_code[0] = SIZE_CODE_0;
        pool_code[1] = SIZE_CODE_1;
        pool_code[2] = SIZE_CODE_2;
        pool_code[3] = SIZE_CODE_3;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: each pool, unknown codes, redundant and uncreated slots, free all.
        issue(REQ_ALLOC,    SIZE_CODE_0, 6'd0);
        issue(REQ_ALLOC,    SIZE_CODE_1, 6'd63);
        issue(REQ_ALLOC,    SIZE_CODE_2, 6'd0);
        issue(REQ_ALLOC,    SIZE_CODE_3, 6'd0);
        issue(REQ_ALLOC,    SIZE_CODE_0, 6'd0);
        issue(REQ_ALLOC,    8'h00,       6'd0);
        issue(REQ_ALLOC,    8'hff,       6'd63);
        issue(REQ_FREE,     SIZE_CODE_0, 6'd0);
        issue(REQ_FREE,     SIZE_CODE_0, 6'd0);
        issue(REQ_USE,      SIZE_CODE_0, 6'd0);
        issue(REQ_USE,      SIZE_CODE_0, 6'd0);
        issue(REQ_FREE,     SIZE_CODE_0, 6'd63);
        issue(REQ_USE,      SIZE_CODE_0, 6'd2);
        issue(REQ_FREE,     8'h55,       6'd63);
        issue(REQ_USE,      8'haa,       6'd42);
        issue(REQ_USE,      8'h00,       6'd21);
        issue(REQ_FREE,     SIZE_CODE_0, 6'd1);
        issue(REQ_ALLOC,    SIZE_CODE_0, 6'd0);
        issue(REQ_FREE_ALL, 8'hff,       6'd63);
        issue(REQ_ALLOC,    SIZE_CODE_1, 6'd0);
        issue(REQ_FREE_ALL, 8'h00,       6'd0);

        // Fill one pool past its cap so that pool full shows up early.
        repeat (SLOTS_DEF + 2) issue(REQ_ALLOC, SIZE_CODE_3, pick_slot());

        while (sent < N_ITEMS) begin
            idle_mode = idle_mode_t'((sent / 200) % 4);
            pick = $urandom_range(0, 99);
            code = pool_code[2'($urandom_range(0, 3))];
            if (pick < 30) begin
                len = (pick < 4) ? $urandom_range(1, 70) : $urandom_range(1, 12);
                repeat (len) issue(REQ_ALLOC, code, pick_slot());
            end else if (pick < 70) begin
                // churn on one pool
                len = $urandom_range(1, 10);
                repeat (len) begin
                    op = $urandom_range(0, 99);
                    if (op < 45)      issue(REQ_FREE,  code, pick_slot());
                    else if (op < 70) issue(REQ_USE,   code, pick_slot());
                    else              issue(REQ_ALLOC, code, pick_slot());
                end
            end else if (pick < 73) begin
                issue(REQ_FREE_ALL, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
            end else begin
                len = $urandom_range(1, 4);
                repeat (len)
                    issue(psa_req_type_t'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (rsp_outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
